/* sv/mlfq_pkg.sv */
// Shared types, codes and helpers for the feedback-queue scheduler.
`default_nettype none
package mlfq_pkg;

  localparam int IdWidth     = 16;
  localparam int SlotWidth   = 6;
  localparam int PeriodWidth = 10;
  localparam int QuantWidth  = 4;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_SETRUN  = 3'd1;
  localparam logic [2:0] ACT_SETPRIO = 3'd2;
  localparam logic [2:0] ACT_LOCK    = 3'd3;
  localparam logic [2:0] ACT_UNLOCK  = 3'd4;
  localparam logic [2:0] ACT_TICK    = 3'd5;
  localparam logic [2:0] ACT_PICK    = 3'd6;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_EMPTY   = 2'd2;
  localparam logic [1:0] STS_NONE    = 2'd3;

  localparam logic [1:0] LEVEL_TOP = 2'd0;
  localparam logic [1:0] PRIO_BASE = 2'd3;

  // slot marks and id
  typedef struct packed {
    logic                 used;
    logic                 runnable;
    logic [IdWidth-1:0]   id;
  } a_word_t;

  // scheduling attributes
  typedef struct packed {
    logic [1:0]            level;
    logic [1:0]            prio;
    logic [QuantWidth-1:0] quantum;
  } b_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_LRD,
    ST_SCAN,
    ST_SEND,
    ST_BOOST,
    ST_DONE
  } seq_state_t;

  function automatic b_word_t refresh_word(logic [QuantWidth-1:0] fq);
    b_word_t r;
    r.level   = LEVEL_TOP;
    r.prio    = PRIO_BASE;
    r.quantum = fq;
    return r;
  endfunction

  // one tick of quantum; when it runs out, drop a level, or at level 2 lower prio
  function automatic b_word_t charge(b_word_t e);
    b_word_t               r;
    logic [QuantWidth-1:0] q;
    r = e;
    q = e.quantum - 4'd1;
    if (q == 4'd0) begin
      if (e.level < 2'd2) begin
        r.level = e.level + 2'd1;
        q = (e.level == 2'd0) ? 4'd6 : 4'd8;
      end else begin
        if (e.prio != 2'd0) r.prio = e.prio - 2'd1;
        q = 4'd8;
      end
    end
    r.quantum = q;
    return r;
  endfunction

  // lower key is served first
  function automatic logic [3:0] sched_key(b_word_t e);
    logic [3:0] k;
    if (e.level >= 2'd2) k = 4'd8 + {2'b00, e.prio};
    else k = {e.level, 2'b00};
    return k;
  endfunction

endpackage
`default_nettype wire

/* sv/mlfq_mem.sv */
// Single-port-write, single-port-read synchronous memory, registered read.
`default_nettype none
module mlfq_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/mlfq_seq.sv */
// Event sequencer: reads, updates and writes back the slot tables.
`default_nettype none
module mlfq_seq import mlfq_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [PeriodWidth-1:0]     boost_period,
  input  wire logic [QuantWidth-1:0]      fresh_quantum,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_action,
  input  wire logic [SlotWidth-1:0]       in_slot,
  input  wire logic [IdWidth-1:0]         in_id,
  input  wire logic                       in_flag,
  input  wire logic [1:0]                 in_prio,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_status,
  output logic [SlotWidth-1:0]            out_chosen,
  output logic                            out_boosted,
  output logic                            a_we,
  output logic [$clog2(NUM_SLOTS)-1:0]    a_waddr,
  output a_word_t                         a_wdata,
  output logic                            b_we,
  output logic [$clog2(NUM_SLOTS)-1:0]    b_waddr,
  output b_word_t                         b_wdata,
  output logic [$clog2(NUM_SLOTS)-1:0]    rd_addr,
  input  a_word_t                         rd_a,
  input  b_word_t                         rd_b
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LastIdx = SW'(NUM_SLOTS - 1);

  seq_state_t state, state_next;

  logic [2:0]             act;
  logic [SlotWidth-1:0]   slot_r;
  logic [IdWidth-1:0]     id_r;
  logic                   flag_r;
  logic [1:0]             prio_r;
  logic                   used_r;
  logic [PeriodWidth-1:0] gcount;
  logic                   lock_valid;
  logic [SW-1:0]          lock_slot;
  logic [SW-1:0]          last_picked;
  logic [SW-1:0]          ptr;
  logic [SW-1:0]          pptr;
  logic [SW-1:0]          cnt;
  logic                   pv;
  logic                   found;
  logic [3:0]             best_key;
  logic [SW-1:0]          best;
  b_word_t                best_b;
  logic [1:0]             res_status;
  logic [SlotWidth-1:0]   res_chosen;
  logic                   res_boost;

  logic          found_next;
  logic [3:0]    best_key_next;
  logic [SW-1:0] best_next;
  b_word_t       best_b_next;
  logic          hit;
  logic [3:0]    key;

  logic [SW-1:0] si;
  logic          ok_slot;
  logic          used_rd;
  logic          boost_hit;
  logic          unlock_ok;
  logic          in_fire;

  function automatic logic [SW-1:0] wrap_inc(logic [SW-1:0] s);
    return (s == LastIdx) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] wrap_dec(logic [SW-1:0] s);
    return (s == '0) ? LastIdx : s - 1'b1;
  endfunction

  assign si        = SW'(slot_r);
  assign ok_slot   = 32'(slot_r) < NUM_SLOTS;
  assign used_rd   = ok_slot && rd_a.used;
  assign boost_hit = gcount >= (boost_period - 10'd1);
  assign unlock_ok = ok_slot && lock_valid && (lock_slot == si);
  assign in_fire   = in_valid && in_ready;

  // compare stage of the table walk
  always_comb begin
    key = sched_key(rd_b);
    if (act == ACT_PICK) begin
      hit = pv && rd_a.used && rd_a.runnable && (!found || key < best_key);
    end else begin
      hit = pv && rd_a.used && !found && (rd_a.id == id_r);
    end
    found_next    = found || hit;
    best_next     = hit ? pptr : best;
    best_key_next = hit ? key : best_key;
    best_b_next   = hit ? rd_b : best_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (ptr == LastIdx) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          priority case (in_action)
            ACT_CREATE, ACT_SETRUN, ACT_LOCK, ACT_UNLOCK, ACT_TICK: state_next = ST_RD;
            ACT_SETPRIO: state_next = ST_SCAN;
            ACT_PICK:    state_next = lock_valid ? ST_RD : ST_SCAN;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_RD: begin
        priority case (act)
          ACT_LOCK: state_next = ST_LRD;
          ACT_TICK: state_next = (used_rd && rd_b.quantum != '0 && boost_hit) ?
                                 ST_BOOST : ST_DONE;
          ACT_PICK: state_next = (rd_a.used && rd_a.runnable) ? ST_DONE : ST_SCAN;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_LRD:   state_next = ST_DONE;
      ST_SCAN:  if (cnt == LastIdx) state_next = ST_SEND;
      ST_SEND:  state_next = ST_DONE;
      ST_BOOST: if (ptr == LastIdx) state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    a_we     = 1'b0;
    a_waddr  = ptr;
    a_wdata  = '0;
    b_we     = 1'b0;
    b_waddr  = ptr;
    b_wdata  = refresh_word(fresh_quantum);
    rd_addr  = ptr;
    unique case (state)
      ST_IDLE: rd_addr = (in_action == ACT_PICK) ? lock_slot : SW'(in_slot);
      ST_RD: begin
        rd_addr = lock_slot;
        a_waddr = si;
        b_waddr = si;
        priority case (act)
          ACT_CREATE: begin
            if (ok_slot && !rd_a.used) begin
              a_we    = 1'b1;
              a_wdata = '{used: 1'b1, runnable: 1'b0, id: id_r};
              b_we    = 1'b1;
            end
          end
          ACT_SETRUN: begin
            if (used_rd) begin
              a_we    = 1'b1;
              a_wdata = '{used: 1'b1, runnable: flag_r, id: rd_a.id};
            end
          end
          ACT_UNLOCK: b_we = unlock_ok;
          ACT_TICK: begin
            if (used_rd && rd_b.quantum != '0) begin
              b_we    = 1'b1;
              b_wdata = charge(rd_b);
            end
          end
          default: ;
        endcase
      end
      ST_SEND: begin
        b_waddr = best_next;
        if (act == ACT_SETPRIO && found_next) begin
          b_we    = 1'b1;
          b_wdata = '{level: best_b_next.level, prio: prio_r,
                      quantum: best_b_next.quantum};
        end
      end
      ST_BOOST: b_we = 1'b1;
      ST_CLEAR: a_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcount      <= '0;
      lock_valid  <= 1'b0;
      lock_slot   <= '0;
      last_picked <= SW'(63 % NUM_SLOTS);
      ptr         <= '0;
      cnt         <= '0;
      pv          <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      pv   <= (state == ST_SCAN);
      pptr <= ptr;
      if (state == ST_SCAN || state == ST_SEND) begin
        found    <= found_next;
        best     <= best_next;
        best_key <= best_key_next;
        best_b   <= best_b_next;
      end
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: ptr <= wrap_inc(ptr);
        ST_IDLE: begin
          if (in_fire) begin
            act        <= in_action;
            slot_r     <= in_slot;
            id_r       <= in_id;
            flag_r     <= in_flag;
            prio_r     <= in_prio;
            found      <= 1'b0;
            cnt        <= '0;
            ptr        <= (in_action == ACT_PICK) ? wrap_inc(last_picked) : '0;
            res_status <= STS_REFUSED;
            res_chosen <= '0;
            res_boost  <= 1'b0;
          end
        end
        ST_RD: begin
          priority case (act)
            ACT_CREATE: if (ok_slot && !rd_a.used) res_status <= STS_OK;
            ACT_SETRUN: if (used_rd) res_status <= STS_OK;
            ACT_LOCK:   used_r <= used_rd;
            ACT_UNLOCK: begin
              if (unlock_ok) begin
                last_picked <= wrap_dec(si);
                lock_valid  <= 1'b0;
                res_status  <= STS_OK;
              end
            end
            ACT_TICK: begin
              if (used_rd) begin
                if (rd_b.quantum == '0) begin
                  res_status <= STS_EMPTY;
                end else begin
                  res_status <= STS_OK;
                  if (boost_hit) begin
                    res_boost <= 1'b1;
                    gcount    <= '0;
                    ptr       <= '0;
                    if (lock_valid) begin
                      last_picked <= wrap_dec(lock_slot);
                      lock_valid  <= 1'b0;
                    end
                  end else begin
                    gcount <= gcount + 10'd1;
                  end
                end
              end
            end
            ACT_PICK: begin
              if (rd_a.used && rd_a.runnable) begin
                res_chosen <= SlotWidth'(lock_slot);
                res_status <= STS_OK;
              end else begin
                lock_valid <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        ST_LRD: begin
          if (used_r) begin
            gcount <= '0;
            if (!(lock_valid && rd_a.runnable)) begin
              lock_valid <= 1'b1;
              lock_slot  <= si;
              res_status <= STS_OK;
            end
          end
        end
        ST_SCAN: begin
          ptr <= wrap_inc(ptr);
          cnt <= cnt + 1'b1;
        end
        ST_SEND: begin
          if (act == ACT_PICK) begin
            if (found_next) begin
              res_chosen  <= SlotWidth'(best_next);
              last_picked <= best_next;
              res_status  <= STS_OK;
            end else begin
              res_status <= STS_NONE;
            end
          end else if (found_next) begin
            res_status <= STS_OK;
          end
        end
        ST_BOOST: ptr <= wrap_inc(ptr);
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_chosen  <= res_chosen;
            out_boosted <= res_boost;
          end
        end
        default: ;
      endcase
    end
  end

  a_lock_from_lock_event: assert property (@(posedge clk) disable iff (rst)
    $rose(lock_valid) |-> $past(state) == ST_LRD)
    else $error("lock taken outside a lock event");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_LRD) |-> !a_we && !b_we)
    else $error("table written during a read-only walk");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result issued outside the done state");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during table clear");

endmodule
`default_nettype wire

/* sv/mlfq_process_scheduler_unit.sv */
// Top level of the feedback-queue scheduler: ports, settings, tables.
//
// Items arrive on the s_ channel (action in s_tuser, arguments in s_tdata)
// and each gives exactly one result item on the m_ channel. Settings are
// written on the cfg_ channel, which is always ready; index 0 is the boost
// period, index 1 the fresh quantum. Write them only while the block idles.
//
// One item is handled at a time. Create, set runnable, unlock, a tick
// without boost and a pick served by the lock read the slot and then give
// the result; lock adds a second read and an unknown action goes straight
// to the result. A pick or set priority walks the slot table one slot per
// cycle through the read port of the tables; a pick that finds the lock
// stale walks after it. A tick that boosts rewrites every slot's attributes.
//
// After reset the block clears the slot marks, one slot per cycle, with
// s_tready low. A result waits in the output register while m_tready is
// low; the next item is still taken and holds until the output register
// frees.
`default_nettype none
module mlfq_process_scheduler_unit import mlfq_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // slot[5:0], task_id[21:6], runnable_flag[22],
                                      // new_priority[24:23], zero fill
  input  wire logic [2:0]  s_tuser,   // action[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // status[1:0], chosen_slot[7:2], boosted[8],
                                      // zero fill
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic CFG_PERIOD = 1'b0;
  localparam logic CFG_QUANT  = 1'b1;

  logic [PeriodWidth-1:0] boost_period;
  logic [QuantWidth-1:0]  fresh_quantum;

  logic          a_we, b_we;
  logic [SW-1:0] a_waddr, b_waddr, rd_addr;
  a_word_t       a_wdata, rd_a;
  b_word_t       b_wdata, rd_b;
  logic [1:0]            out_status;
  logic [SlotWidth-1:0]  out_chosen;
  logic                  out_boosted;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      boost_period  <= 10'd100;
      fresh_quantum <= 4'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PERIOD: boost_period  <= cfg_data;
        CFG_QUANT:  fresh_quantum <= cfg_data[QuantWidth-1:0];
        default: ;
      endcase
    end
  end

  mlfq_mem #(.WIDTH($bits(a_word_t)), .DEPTH(NUM_SLOTS)) u_mem_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (rd_addr),
    .rdata (rd_a)
  );

  mlfq_mem #(.WIDTH($bits(b_word_t)), .DEPTH(NUM_SLOTS)) u_mem_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (rd_addr),
    .rdata (rd_b)
  );

  mlfq_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .boost_period  (boost_period),
    .fresh_quantum (fresh_quantum),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_action     (s_tuser),
    .in_slot       (s_tdata[5:0]),
    .in_id         (s_tdata[21:6]),
    .in_flag       (s_tdata[22]),
    .in_prio       (s_tdata[24:23]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (out_status),
    .out_chosen    (out_chosen),
    .out_boosted   (out_boosted),
    .a_we          (a_we),
    .a_waddr       (a_waddr),
    .a_wdata       (a_wdata),
    .b_we          (b_we),
    .b_waddr       (b_waddr),
    .b_wdata       (b_wdata),
    .rd_addr       (rd_addr),
    .rd_a          (rd_a),
    .rd_b          (rd_b)
  );

  assign m_tdata = {7'd0, out_boosted, out_chosen, out_status};

endmodule
`default_nettype wire
